// File: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer: field widths,
// command codes, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int OPC_W     = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 4;
    localparam int CELL_W    = 16;
    localparam int ADDR_IN_W = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    // compare width for read addresses, covers 128 x 128 cells
    localparam int CMP_W     = 14;

    localparam logic [OPC_W-1:0] OP_PRINT = 2'd0;
    localparam logic [OPC_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPC_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE      = 8'd10;
    localparam logic [CHAR_W-1:0] LAST_CONTROL = 8'd31;
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0020;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic exec;
        logic sweep_step;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic             need_scroll;
        logic             sweep_last;
        logic             out_free;
    } t_ctrl_status;

endpackage

// File: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: accept, execute, optional buffer sweep (scroll or clear),
// then hand the result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  tcw_pkg::t_ctrl_status i_status,
    output tcw_pkg::t_ctrl_cmd    o_cmd
);
    import tcw_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    always_comb begin
        o_in_ready = (r_state == ST_IDLE) || ((r_state == ST_DONE) && i_status.out_free);
        accept     = i_in_valid && o_in_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.opcode == OP_CLEAR) begin
                    n_state = ST_SWEEP;
                end else if ((i_status.opcode == OP_PRINT) && i_status.need_scroll) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (i_status.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.latch = accept;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            ST_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
            end
            ST_DONE: begin
                o_cmd.load_out = i_status.out_free;
                o_cmd.latch    = accept;
            end
            default: o_cmd = '0;
        endcase
    end

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request not executed next cycle");

    a_sweep_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && !i_status.sweep_last) |=> (r_state == ST_SWEEP))
        else $error("sweep left before its last cell");

    a_done_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SWEEP) && i_status.sweep_last) |=> (r_state == ST_DONE))
        else $error("sweep end did not reach result state");

endmodule

// File: rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen buffer, cursor, sweep counter for scroll and clear, output register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tcw_pkg::t_ctrl_cmd              i_cmd,
    output tcw_pkg::t_ctrl_status           o_status,
    input  logic [tcw_pkg::OPC_W-1:0]       i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_fore_color,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_back_color,
    input  logic [tcw_pkg::ADDR_IN_W-1:0]   i_cell_address,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   o_cursor_column,
    output logic                            o_scrolled
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLUMNS);

    // latched request
    logic [OPC_W-1:0]     r_opcode;
    logic [CHAR_W-1:0]    r_char;
    logic [COLOR_W-1:0]   r_fore;
    logic [COLOR_W-1:0]   r_back;
    logic [ADDR_IN_W-1:0] r_addr;

    // cursor; r_base tracks row * COLUMNS
    logic [ROW_W-1:0]  r_cur_row, n_cur_row;
    logic [COL_W-1:0]  r_cur_col, n_cur_col;
    logic [ADDR_W-1:0] r_base, n_base;
    logic              r_scroll, n_scroll;
    logic              r_read_ok, n_read_ok;

    // sweep and delayed write
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic              r_copy_mode, n_copy_mode;
    logic              r_pend_we, n_pend_we;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic              r_pend_blank, n_pend_blank;

    logic              r_out_valid;
    logic [CELL_W-1:0] r_out_data;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic              r_out_scroll;

    logic              is_nl;
    logic              to_space;
    logic [CHAR_W-1:0] eff_char;
    logic              row_inc;
    logic              need_scroll;
    logic              copy_now;
    logic [CMP_W-1:0]  addr_ext;
    logic              addr_ok;
    logic              exec_we;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_char   <= i_char_code;
            r_fore   <= i_fore_color;
            r_back   <= i_back_color;
            r_addr   <= i_cell_address;
        end
    end

    always_comb begin
        is_nl       = (r_char == NEWLINE);
        to_space    = ((r_char <= LAST_CONTROL) && !is_nl) || r_char[CHAR_W-1];
        eff_char    = to_space ? SPACE_CHAR : r_char;
        row_inc     = is_nl || (r_cur_col == COL_W'(COLUMNS - 1));
        need_scroll = row_inc && (r_cur_row == ROW_W'(ROWS - 1));
        copy_now    = r_copy_mode && (r_sweep < ADDR_W'(COPY_COUNT));
        addr_ext    = CMP_W'(r_addr);
        addr_ok     = addr_ext < CMP_W'(CELL_COUNT);
        exec_we     = i_cmd.exec && (r_opcode == OP_PRINT) && !is_nl;
    end

    always_comb begin
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_base       = r_base;
        n_scroll     = r_scroll;
        n_read_ok    = r_read_ok;
        n_sweep      = r_sweep;
        n_copy_mode  = r_copy_mode;
        n_pend_we    = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_pend_blank = r_pend_blank;
        if (i_cmd.exec) begin
            n_scroll    = 1'b0;
            n_read_ok   = (r_opcode == OP_READ) && addr_ok;
            n_sweep     = '0;
            n_copy_mode = (r_opcode == OP_PRINT);
            case (r_opcode)
                OP_PRINT: begin
                    if (need_scroll) begin
                        n_cur_row = ROW_W'(ROWS - 1);
                        n_cur_col = '0;
                        n_scroll  = 1'b1;
                    end else if (row_inc) begin
                        n_cur_row = r_cur_row + 1'b1;
                        n_cur_col = '0;
                        n_base    = ADDR_W'(r_base + ADDR_W'(COLUMNS));
                    end else begin
                        n_cur_col = r_cur_col + 1'b1;
                    end
                end
                OP_CLEAR: begin
                    n_cur_row = '0;
                    n_cur_col = '0;
                    n_base    = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.sweep_step) begin
            n_pend_we    = 1'b1;
            n_pend_addr  = r_sweep;
            n_pend_blank = !copy_now;
            n_sweep      = r_sweep + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_row <= '0;
            r_cur_col <= '0;
            r_base    <= '0;
            r_pend_we <= 1'b0;
        end else begin
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_base    <= n_base;
            r_pend_we <= n_pend_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scroll     <= n_scroll;
        r_read_ok    <= n_read_ok;
        r_sweep      <= n_sweep;
        r_copy_mode  <= n_copy_mode;
        r_pend_addr  <= n_pend_addr;
        r_pend_blank <= n_pend_blank;
    end

    // print write and cell read; row scroll: read one row below, write it back in the next cycle
    always_comb begin
        ram_we    = r_pend_we || exec_we;
        ram_waddr = r_pend_we ? r_pend_addr
                              : ADDR_W'(r_base + ADDR_W'(r_cur_col));
        ram_wdata = r_pend_we ? (r_pend_blank ? BLANK_CELL : ram_rdata)
                              : {r_back, r_fore, eff_char};
        ram_re    = (i_cmd.exec && (r_opcode == OP_READ) && addr_ok)
                    || (i_cmd.sweep_step && copy_now);
        ram_raddr = i_cmd.sweep_step ? ADDR_W'(r_sweep + ADDR_W'(COLUMNS))
                                     : ADDR_W'(addr_ext);
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data   <= r_read_ok ? ram_rdata : '0;
            r_out_row    <= r_cur_row;
            r_out_col    <= r_cur_col;
            r_out_scroll <= r_scroll;
        end
    end

    always_comb begin
        o_status.opcode      = r_opcode;
        o_status.need_scroll = need_scroll;
        o_status.sweep_last  = (r_sweep == ADDR_W'(CELL_COUNT - 1));
        o_status.out_free    = !r_out_valid || i_out_ready;
        o_out_valid          = r_out_valid;
        o_cell_data          = r_out_data;
        o_cursor_row         = ROW_OUT_W'(r_out_row);
        o_cursor_column      = COL_OUT_W'(r_out_col);
        o_scrolled           = r_out_scroll;
    end

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_row < ROW_W'(ROWS - 1)) || (r_cur_row == ROW_W'(ROWS - 1)))
        else $error("cursor row out of range");

    a_base_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base == ADDR_W'(r_cur_row * COLUMNS))
        else $error("row base out of step with cursor row");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_we |-> !exec_we)
        else $error("sweep write collides with print write");

endmodule

// File: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine: COLUMNS x ROWS cell buffer with cursor; print, clear
// and cell read requests, one result per request.
// ----------------------------------------------------------------------------
// Flow: print without scroll and read pass the execute and result states;
//   print with scroll and clear also sweep all COLUMNS*ROWS cells (2000 at
//   80 x 25), one buffer cell per cycle through the single RAM write port.
// A new request can be taken as the last result is loaded to the output.
// Reset: cursor homed, no request in flight, output empty; buffer contents
//   stay undefined until written.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tcw_pkg::OPC_W-1:0]       i_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]      i_char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_fore_color,
    input  logic [tcw_pkg::COLOR_W-1:0]     i_back_color,
    input  logic [tcw_pkg::ADDR_IN_W-1:0]   i_cell_address,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tcw_pkg::CELL_W-1:0]      o_cell_data,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   o_cursor_column,
    output logic                            o_scrolled
);
    import tcw_pkg::*;

    t_ctrl_cmd    cmd;
    t_ctrl_status status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_fore_color    (i_fore_color),
        .i_back_color    (i_back_color),
        .i_cell_address  (i_cell_address),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_cell_data     (o_cell_data),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_scrolled      (o_scrolled)
    );

endmodule

// File: dv/text_console_writer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console engine. A local screen image,
// with its own cursor, predicts every request. It records which cells hold
// defined data, so reads only go to written cells or to out-of-range
// addresses. Directed tests cover character mapping, the unused opcode,
// clear, row wrap and scrolling. Random traffic then runs under several
// idle and stall mixes on both channels.
// ----------------------------------------------------------------------------
module text_console_writer_tb;
    import tcw_pkg::*;

    localparam int COLS        = DEF_COLUMNS;
    localparam int ROWS        = DEF_ROWS;
    localparam int CELLS       = COLS * ROWS;
    localparam int ADDR_TOP    = 2 ** ADDR_IN_W - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 16;
    localparam int RANDOM_ITEMS_PER_PHASE = 375;

    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [OPC_W-1:0]     opcode;
        logic [CHAR_W-1:0]    char_code;
        logic [COLOR_W-1:0]   fore_color;
        logic [COLOR_W-1:0]   back_color;
        logic [ADDR_IN_W-1:0] cell_address;
    } t_request;

    typedef struct packed {
        logic [CELL_W-1:0]    cell_data;
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_column;
        logic                 scrolled;
    } t_result;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic [OPC_W-1:0]     i_opcode       = OP_PRINT;
    logic [CHAR_W-1:0]    i_char_code    = '0;
    logic [COLOR_W-1:0]   i_fore_color   = '0;
    logic [COLOR_W-1:0]   i_back_color   = '0;
    logic [ADDR_IN_W-1:0] i_cell_address = '0;
    logic                 i_out_ready    = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [CELL_W-1:0]    o_cell_data;
    logic [ROW_OUT_W-1:0] o_cursor_row;
    logic [COL_OUT_W-1:0] o_cursor_column;
    logic                 o_scrolled;

    text_console_writer i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_char_code     (i_char_code),
        .i_fore_color    (i_fore_color),
        .i_back_color    (i_back_color),
        .i_cell_address  (i_cell_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_data     (o_cell_data),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_column (o_cursor_column),
        .o_scrolled      (o_scrolled)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // screen image and cursor
    logic [CELL_W-1:0] screen_image [CELLS];
    bit                cell_known   [CELLS];
    int                cursor_r;
    int                cursor_c;

    t_result     console_results_due[$];
    int          mismatch_count;
    int          print_count;
    int          read_count;
    int          clear_count;
    int          scroll_count;
    int          idle_cycles;
    int unsigned sender_idle_pct;
    int unsigned receiver_stall_pct;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
    endtask

    function automatic t_result predict_console_result(input t_request req);
        t_result           res;
        logic [CHAR_W-1:0] ch;
        res = '0;
        case (req.opcode)
            OP_PRINT: begin
                print_count++;
                ch = req.char_code;
                if ((ch <= LAST_CONTROL && ch != NEWLINE) || ch[CHAR_W-1]) begin
                    ch = SPACE_CHAR;
                end
                if (ch == NEWLINE) begin
                    cursor_r++;
                    cursor_c = 0;
                end else begin
                    screen_image[cursor_r * COLS + cursor_c] =
                        {req.back_color, req.fore_color, ch};
                    cell_known[cursor_r * COLS + cursor_c] = 1'b1;
                    cursor_c++;
                end
                if (cursor_c >= COLS) begin
                    cursor_c = 0;
                    cursor_r++;
                end
                if (cursor_r >= ROWS) begin
                    for (int i = 0; i < CELLS - COLS; i++) begin
                        screen_image[i] = screen_image[i + COLS];
                        cell_known[i]   = cell_known[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++) begin
                        screen_image[i] = BLANK_CELL;
                        cell_known[i]   = 1'b1;
                    end
                    cursor_r     = ROWS - 1;
                    cursor_c     = 0;
                    res.scrolled = 1'b1;
                    scroll_count++;
                end
            end
            OP_CLEAR: begin
                clear_count++;
                for (int i = 0; i < CELLS; i++) begin
                    screen_image[i] = BLANK_CELL;
                    cell_known[i]   = 1'b1;
                end
                cursor_r = 0;
                cursor_c = 0;
            end
            OP_READ: begin
                read_count++;
                if (req.cell_address < CELLS) begin
                    res.cell_data = screen_image[req.cell_address];
                end
            end
            default: ;
        endcase
        res.cursor_row    = ROW_OUT_W'(cursor_r);
        res.cursor_column = COL_OUT_W'(cursor_c);
        return res;
    endfunction

    function automatic t_request make_request(input logic [OPC_W-1:0] op,
                                              input logic [CHAR_W-1:0] ch);
        t_request req;
        req.opcode       = op;
        req.char_code    = ch;
        req.fore_color   = COLOR_W'($urandom);
        req.back_color   = COLOR_W'($urandom);
        req.cell_address = ADDR_IN_W'($urandom_range(ADDR_TOP));
        return req;
    endfunction

    function automatic t_request read_request(input int addr);
        t_request req;
        req              = make_request(OP_READ, CHAR_W'($urandom));
        req.cell_address = ADDR_IN_W'(addr);
        return req;
    endfunction

    // written cell from a random start, else an address past the grid
    function automatic int pick_read_address();
        int start;
        int idx;
        if ($urandom_range(99) < 15) begin
            return $urandom_range(ADDR_TOP, CELLS);
        end
        start = $urandom_range(CELLS - 1);
        for (int k = 0; k < CELLS; k++) begin
            idx = (start + k) % CELLS;
            if (cell_known[idx]) begin
                return idx;
            end
        end
        return CELLS;
    endfunction

    function automatic t_request random_request();
        int unsigned sel;
        int unsigned kind;
        logic [CHAR_W-1:0] ch;
        sel = $urandom_range(999);
        if (sel < 2) begin
            return make_request(OP_CLEAR, CHAR_W'($urandom));
        end else if (sel < 25) begin
            return make_request(OP_UNUSED, CHAR_W'($urandom));
        end else if (sel < 330) begin
            return read_request(pick_read_address());
        end
        kind = $urandom_range(99);
        if (kind < 12) begin
            ch = NEWLINE;
        end else if (kind < 24) begin
            ch = CHAR_W'($urandom_range(255));
        end else begin
            ch = CHAR_W'($urandom_range(126, 32));
        end
        return make_request(OP_PRINT, ch);
    endfunction

    task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
        sender_idle_pct    = send_pct;
        receiver_stall_pct = stall_pct;
    endtask

    task automatic send_request(input t_request req);
        int unsigned gap;
        gap = 0;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_opcode       <= req.opcode;
        i_char_code    <= req.char_code;
        i_fore_color   <= req.fore_color;
        i_back_color   <= req.back_color;
        i_cell_address <= req.cell_address;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        console_results_due.push_back(predict_console_result(req));
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (console_results_due.size() != 0);
    endtask

    task automatic test_idle_state();
        set_idling(0, 0);
        send_request(read_request(ADDR_TOP));
        send_request(read_request(CELLS));
        send_request(make_request(OP_UNUSED, 8'hff));
        hold_until_drained();
    endtask

    task automatic test_char_mapping();
        t_request req;
        req            = make_request(OP_PRINT, 8'h41);
        req.fore_color = '1;
        req.back_color = '1;
        send_request(req);
        req            = make_request(OP_PRINT, 8'h00);
        req.fore_color = '0;
        req.back_color = '0;
        send_request(req);
        send_request(make_request(OP_PRINT, LAST_CONTROL));
        send_request(make_request(OP_PRINT, SPACE_CHAR));
        send_request(make_request(OP_PRINT, 8'd126));
        send_request(make_request(OP_PRINT, 8'd127));
        send_request(make_request(OP_PRINT, 8'd128));
        send_request(make_request(OP_PRINT, 8'd255));
        send_request(read_request(0));
        send_request(read_request(1));
        send_request(read_request(5));
        send_request(read_request(7));
        send_request(make_request(OP_PRINT, NEWLINE));
        send_request(make_request(OP_PRINT, 8'h5a));
        send_request(read_request(COLS));
        hold_until_drained();
    endtask

    task automatic test_clear_screen();
        send_request(make_request(OP_CLEAR, CHAR_W'($urandom)));
        send_request(read_request(0));
        send_request(read_request(CELLS - 1));
        hold_until_drained();
    endtask

    task automatic test_row_wrap_and_scroll();
        set_idling(25, 25);
        send_request(make_request(OP_CLEAR, CHAR_W'($urandom)));
        for (int i = 0; i < COLS; i++) begin
            send_request(make_request(OP_PRINT, CHAR_W'($urandom_range(126, 32))));
        end
        send_request(read_request($urandom_range(COLS - 1)));
        for (int i = 0; i < ROWS; i++) begin
            send_request(make_request(OP_PRINT, NEWLINE));
        end
        for (int i = 0; i < COLS; i++) begin
            send_request(make_request(OP_PRINT, CHAR_W'($urandom_range(255))));
        end
        send_request(read_request($urandom_range(CELLS - COLS - 1, CELLS - 2 * COLS)));
        send_request(read_request($urandom_range(CELLS - 1, CELLS - COLS)));
        hold_until_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned send_mix  [4] = '{0, 61, 0, 25};
        int unsigned stall_mix [4] = '{0, 0, 61, 25};
        for (int p = 0; p < 4; p++) begin
            set_idling(send_mix[p], stall_mix[p]);
            for (int i = 0; i < RANDOM_ITEMS_PER_PHASE; i++) begin
                send_request(random_request());
            end
            hold_until_drained();
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result due;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (console_results_due.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                due = console_results_due.pop_front();
                if (o_cell_data !== due.cell_data) begin
                    report_mismatch($sformatf("cell_data %h, expected %h",
                                              o_cell_data, due.cell_data));
                end
                if (o_cursor_row !== due.cursor_row) begin
                    report_mismatch($sformatf("cursor_row %0d, expected %0d",
                                              o_cursor_row, due.cursor_row));
                end
                if (o_cursor_column !== due.cursor_column) begin
                    report_mismatch($sformatf("cursor_column %0d, expected %0d",
                                              o_cursor_column, due.cursor_column));
                end
                if (o_scrolled !== due.scrolled) begin
                    report_mismatch($sformatf("scrolled %b, expected %b",
                                              o_scrolled, due.scrolled));
                end
            end
        end
        i_out_ready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1)
                || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("text_console_writer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        cursor_r = 0;
        cursor_c = 0;
        for (int i = 0; i < CELLS; i++) begin
            cell_known[i] = 1'b0;
        end
        set_idling(0, 0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_state();
        test_char_mapping();
        test_clear_screen();
        test_row_wrap_and_scroll();
        test_random_traffic();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (console_results_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", console_results_due.size()));
        end
        $display("covered %0d prints, %0d reads, %0d clears, %0d scrolls",
                 print_count, read_count, clear_count, scroll_count);
        $display("under no idling, sender idling, receiver stalls and both; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("text_console_writer_tb: PASS");
        end else begin
            $display("text_console_writer_tb: FAIL");
        end
        $finish;
    end
endmodule

// File: text_console_writer.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer.sv
dv/text_console_writer_tb.sv
